[hdl/gscr_pkg.sv]
package gscr_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BTN_CODE_W = 17;
    localparam int LEN_W      = 5;

    localparam logic [BTN_CODE_W-1:0] BTN_CODE_RST = 17'h10000;

    localparam logic [7:0] CMD_STATUS   = 8'h40;
    localparam logic [7:0] CMD_QUERY    = 8'h41;
    localparam logic [7:0] CMD_POLL     = 8'h42;
    localparam logic [7:0] CMD_CONFIG   = 8'h43;
    localparam logic [7:0] CMD_SET_MODE = 8'h44;
    localparam logic [7:0] CMD_INFO     = 8'h45;
    localparam logic [7:0] CMD_ACT      = 8'h46;
    localparam logic [7:0] CMD_COMB     = 8'h47;
    localparam logic [7:0] CMD_MODE_ID  = 8'h4c;
    localparam logic [7:0] CMD_RUMBLE   = 8'h4d;
    localparam logic [7:0] CMD_NATIVE   = 8'h4f;

    localparam logic [1:0] ACT_CMD     = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_AXIS    = 2'd3;

    localparam logic [1:0] MODE_DIGITAL = 2'd0;
    localparam logic [1:0] MODE_ANALOG  = 2'd1;
    localparam logic [1:0] MODE_PRESS   = 2'd2;

    localparam logic [7:0] ID_DIGITAL = 8'h41;
    localparam logic [7:0] ID_ANALOG  = 8'h73;
    localparam logic [7:0] ID_PRESS   = 8'h79;
    localparam logic [7:0] ID_CONFIG  = 8'hf3;
    localparam logic [7:0] BYTE_ACK   = 8'h5a;
    localparam logic [7:0] BYTE_IDLE  = 8'hff;

    localparam logic [7:0]  AXIS_RST   = 8'h7f;
    localparam logic [15:0] BTN_RST    = 16'hffff;
    localparam logic [7:0]  MASK_RST   = 8'hff;
    localparam logic [7:0]  RUMBLE_RST = 8'hff;

    localparam logic [LEN_W-1:0] LEN_DIGITAL = 5'd5;
    localparam logic [LEN_W-1:0] LEN_SHORT   = 5'd9;
    localparam logic [LEN_W-1:0] LEN_FULL    = 5'd21;

    typedef enum logic [3:0] {
        RK_PAD,
        RK_ZERO,
        RK_STATUS,
        RK_CFG,
        RK_INFO,
        RK_ACT,
        RK_COMB,
        RK_MODE,
        RK_RUMBLE,
        RK_NATIVE
    } t_rsp_kind;

    typedef struct packed {
        t_rsp_kind         kind;
        logic              flag;
        logic [LEN_W-1:0]  len;
        logic [7:0]        model;
        logic [15:0]       buttons;
        logic [3:0][7:0]   axes;
        logic [7:0]        d0;
        logic [7:0]        d1;
    } t_rsp_desc;

    function automatic logic [7:0] rsp_byte(t_rsp_desc d, logic [LEN_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx == 5'd0) begin
            b = BYTE_IDLE;
        end else if (idx == 5'd1) begin
            b = (d.kind == RK_PAD) ? d.model : ID_CONFIG;
        end else if (idx == 5'd2) begin
            b = BYTE_ACK;
        end else begin
            unique case (d.kind)
                RK_PAD: begin
                    case (idx)
                        5'd3:    b = d.buttons[7:0];
                        5'd4:    b = d.buttons[15:8];
                        5'd5:    b = d.axes[1];
                        5'd6:    b = d.axes[0];
                        5'd7:    b = d.axes[3];
                        5'd8:    b = d.axes[2];
                        default: b = BYTE_IDLE;
                    endcase
                end
                RK_STATUS: begin
                    case (idx)
                        5'd5:    b = 8'h02;
                        5'd8:    b = BYTE_ACK;
                        default: b = 8'h00;
                    endcase
                end
                RK_CFG: begin
                    case (idx)
                        5'd3:    b = d.d0;
                        5'd4:    b = d.d1;
                        5'd5:    b = 8'h03;
                        5'd8:    b = BYTE_ACK;
                        default: b = 8'h00;
                    endcase
                end
                RK_INFO: begin
                    case (idx)
                        5'd3:    b = 8'h03;
                        5'd4:    b = 8'h02;
                        5'd5:    b = {7'd0, d.flag};
                        5'd6:    b = 8'h02;
                        5'd7:    b = 8'h01;
                        default: b = 8'h00;
                    endcase
                end
                RK_ACT: begin
                    case (idx)
                        5'd5:    b = 8'h01;
                        5'd6:    b = d.flag ? 8'h01 : 8'h02;
                        5'd7:    b = d.flag ? 8'h01 : 8'h00;
                        5'd8:    b = d.flag ? 8'h14 : 8'h0a;
                        default: b = 8'h00;
                    endcase
                end
                RK_COMB: begin
                    case (idx)
                        5'd5:    b = 8'h02;
                        5'd7:    b = 8'h01;
                        default: b = 8'h00;
                    endcase
                end
                RK_MODE: begin
                    b = (idx == 5'd6) ? (d.flag ? 8'h07 : 8'h04) : 8'h00;
                end
                RK_RUMBLE: begin
                    case (idx)
                        5'd3:    b = d.d0;
                        5'd4:    b = d.d1;
                        default: b = BYTE_IDLE;
                    endcase
                end
                RK_NATIVE: begin
                    b = (idx == 5'd8) ? BYTE_ACK : 8'h00;
                end
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

[hdl/gscr_cmd_if.sv]
interface gscr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  command_code;
    logic [7:0]  arg_a;
    logic [7:0]  arg_b;
    logic [7:0]  arg_c;
    logic [7:0]  arg_d;
    logic [16:0] button_mask;
    logic [1:0]  axis_select;
    logic [7:0]  axis_value;

    modport source (
        output valid, action, command_code, arg_a, arg_b, arg_c, arg_d,
               button_mask, axis_select, axis_value,
        input  ready
    );
    modport sink (
        input  valid, action, command_code, arg_a, arg_b, arg_c, arg_d,
               button_mask, axis_select, axis_value,
        output ready
    );
endinterface

[hdl/gscr_rsp_if.sv]
interface gscr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] response_byte;
    logic       last_byte;

    modport source (output valid, response_byte, last_byte, input ready);
    modport sink (input valid, response_byte, last_byte, output ready);
endinterface

[hdl/gscr_front.sv]
module gscr_front
    import gscr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [BTN_CODE_W-1:0] i_cfg_wdata,
    gscr_cmd_if.sink              i_cmd,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_rsp_desc             o_q_desc
);

    logic [BTN_CODE_W-1:0] r_btn_code;
    logic [1:0]            r_mode,    n_mode;
    logic                  r_locked,  n_locked;
    logic                  r_cfg,     n_cfg;
    logic [7:0]            r_mask0,   n_mask0;
    logic [7:0]            r_mask1,   n_mask1;
    logic [7:0]            r_rumble0, n_rumble0;
    logic [7:0]            r_rumble1, n_rumble1;
    logic [15:0]           r_buttons, n_buttons;
    logic [3:0][7:0]       r_axes,    n_axes;

    logic      accept;
    logic      known;
    logic      arg_nz;
    t_rsp_desc desc;

    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign arg_nz      = i_cmd.arg_a != 8'd0;

    // classify command into a response descriptor, snapshotting state
    always_comb begin
        known        = 1'b1;
        desc.kind    = RK_ZERO;
        desc.flag    = 1'b0;
        desc.len     = LEN_SHORT;
        desc.model   = (r_mode == MODE_DIGITAL) ? ID_DIGITAL : ID_ANALOG;
        desc.buttons = r_buttons;
        desc.axes    = r_axes;
        desc.d0      = r_mask0;
        desc.d1      = r_mask1;
        case (i_cmd.command_code)
            CMD_STATUS:   desc.kind = RK_STATUS;
            CMD_QUERY:    desc.kind = (r_mode == MODE_DIGITAL) ? RK_ZERO : RK_CFG;
            CMD_POLL: begin
                desc.kind = RK_PAD;
                if (r_mode == MODE_DIGITAL) begin
                    desc.len = LEN_DIGITAL;
                end else if (r_mode == MODE_ANALOG) begin
                    desc.len = LEN_SHORT;
                end else begin
                    desc.len   = LEN_FULL;
                    desc.model = ID_PRESS;
                end
            end
            CMD_CONFIG: begin
                if (!r_cfg) begin
                    desc.kind = RK_PAD;
                    desc.len  = (r_mode == MODE_DIGITAL) ? LEN_DIGITAL : LEN_SHORT;
                end
            end
            CMD_SET_MODE: desc.kind = RK_ZERO;
            CMD_INFO: begin
                desc.kind = RK_INFO;
                desc.flag = r_mode != MODE_DIGITAL;
            end
            CMD_ACT: begin
                desc.kind = RK_ACT;
                desc.flag = arg_nz;
            end
            CMD_COMB:     desc.kind = RK_COMB;
            CMD_MODE_ID: begin
                desc.kind = RK_MODE;
                desc.flag = arg_nz;
            end
            CMD_RUMBLE: begin
                desc.kind = RK_RUMBLE;
                desc.d0   = r_rumble0;
                desc.d1   = r_rumble1;
            end
            CMD_NATIVE:   desc.kind = RK_NATIVE;
            default:      known = 1'b0;
        endcase
    end

    assign o_q_push = accept && (i_cmd.action == ACT_CMD) && known;
    assign o_q_desc = desc;

    always_comb begin
        n_mode    = r_mode;
        n_locked  = r_locked;
        n_cfg     = r_cfg;
        n_mask0   = r_mask0;
        n_mask1   = r_mask1;
        n_rumble0 = r_rumble0;
        n_rumble1 = r_rumble1;
        n_buttons = r_buttons;
        n_axes    = r_axes;
        if (accept) begin
            unique case (i_cmd.action)
                ACT_CMD: begin
                    case (i_cmd.command_code)
                        CMD_CONFIG: n_cfg = arg_nz;
                        CMD_SET_MODE: begin
                            if (i_cmd.arg_a < 8'd2 && !r_locked) begin
                                n_mode = i_cmd.arg_a[1:0];
                            end
                            n_locked = i_cmd.arg_b == 8'h03;
                        end
                        CMD_RUMBLE: begin
                            n_rumble0 = i_cmd.arg_a;
                            n_rumble1 = i_cmd.arg_b;
                        end
                        CMD_NATIVE: begin
                            n_mask0 = i_cmd.arg_a;
                            n_mask1 = i_cmd.arg_b;
                            priority if (!i_cmd.arg_c[0]) begin
                                n_mode = MODE_DIGITAL;
                            end else if (!i_cmd.arg_c[1]) begin
                                n_mode = MODE_ANALOG;
                            end else begin
                                n_mode = MODE_PRESS;
                            end
                        end
                        default: ;
                    endcase
                end
                ACT_PRESS: begin
                    if (i_cmd.button_mask == r_btn_code) begin
                        if (!r_locked) begin
                            n_mode = (r_mode != MODE_DIGITAL) ? MODE_DIGITAL : MODE_ANALOG;
                        end
                    end else begin
                        n_buttons = r_buttons & ~i_cmd.button_mask[15:0];
                    end
                end
                ACT_RELEASE: n_buttons = r_buttons | i_cmd.button_mask[15:0];
                ACT_AXIS:    n_axes[i_cmd.axis_select] = i_cmd.axis_value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_code <= BTN_CODE_RST;
            r_mode     <= MODE_DIGITAL;
            r_locked   <= 1'b0;
            r_cfg      <= 1'b0;
            r_mask0    <= MASK_RST;
            r_mask1    <= MASK_RST;
            r_rumble0  <= RUMBLE_RST;
            r_rumble1  <= RUMBLE_RST;
            r_buttons  <= BTN_RST;
            r_axes     <= {4{AXIS_RST}};
        end else begin
            if (i_cfg_we) begin
                r_btn_code <= i_cfg_wdata;
            end
            r_mode    <= n_mode;
            r_locked  <= n_locked;
            r_cfg     <= n_cfg;
            r_mask0   <= n_mask0;
            r_mask1   <= n_mask1;
            r_rumble0 <= n_rumble0;
            r_rumble1 <= n_rumble1;
            r_buttons <= n_buttons;
            r_axes    <= n_axes;
        end
    end

    a_lock_holds_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.action == ACT_PRESS && i_cmd.button_mask == r_btn_code && r_locked
        |=> $stable(r_mode))
        else $error("locked mode changed by analog button");

    a_mode_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != 2'd3)
        else $error("pad mode reached unused code");

endmodule

[hdl/gscr_queue.sv]
module gscr_queue
    import gscr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_rsp_desc i_desc,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_rsp_desc o_desc
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_rsp_desc         r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

[hdl/gscr_back.sv]
module gscr_back
    import gscr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_rsp_desc i_q_desc,
    output logic      o_q_pop,
    gscr_rsp_if.source o_rsp
);

    logic             r_busy;
    t_rsp_desc        r_cur;
    logic [LEN_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic emit;
    logic is_last;
    logic load;

    assign emit    = r_busy && (!r_out_valid || o_rsp.ready);
    assign is_last = r_idx == (r_cur.len - 1'b1);
    assign load    = i_q_valid && (!r_busy || (emit && is_last));
    assign o_q_pop = load;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.response_byte = r_out_byte;
    assign o_rsp.last_byte     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_desc;
        end
        if (emit) begin
            r_out_byte <= rsp_byte(r_cur, r_idx);
            r_out_last <= is_last;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_cur.len))
        else $error("byte index past response length");

    a_last_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && is_last && !load |=> !r_busy)
        else $error("response continued past last beat");

endmodule

[hdl/gamepad_serial_command_responder_unit.sv]
// Channel   Dir  Payload                                          Beat
// i_cmd     in   action, command_code, arg_a..arg_d,              one item
//                button_mask, axis_select, axis_value
// o_rsp     out  response_byte, last_byte                         one byte
// i_cfg_*   in   analog_button_code (17 bits)                     one write
//
// Input items enter at one per cycle while the descriptor queue (default depth 4)
// has room; state updates land at the accepting edge.
// Output runs one byte per cycle from the back end while o_rsp is ready: a
// command with N bytes (5, 9 or 21) gives N o_rsp beats; unknown commands and
// button or axis items give no beats. Reset is synchronous and active low.
// o_rsp stalls hold the output register; i_cmd stalls only when the queue is full.
module gamepad_serial_command_responder_unit
    import gscr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [BTN_CODE_W-1:0] i_cfg_wdata,
    gscr_cmd_if.sink              i_cmd,
    gscr_rsp_if.source            o_rsp
);

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_valid;
    t_rsp_desc q_in;
    t_rsp_desc q_out;

    gscr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_desc    (q_in)
    );

    gscr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_out)
    );

    gscr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_out),
        .o_q_pop   (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule
